// ===== hdl/sjsp_pkg.sv =====
// Package with payload types, constants and fixed tables for the slew profiler.
`default_nettype none
package sjsp_pkg;

  localparam int JOINT_COUNT_DEF = 4;
  localparam int MAX_EMIT        = 4;
  localparam logic [31:0] MIN_TICK_MS = 32'd20;
  localparam logic [7:0] STAGE0_MASK = 8'b0000_1001;
  localparam logic [7:0] STAGE1_MASK = 8'b0000_0110;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_HOME  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [2:0] REG_JOINTS = 3'd0;
  localparam logic [2:0] REG_PMIN   = 3'd1;
  localparam logic [2:0] REG_PMAX   = 3'd2;
  localparam logic [2:0] REG_ACCEL  = 3'd3;
  localparam logic [2:0] REG_MAXR   = 3'd4;
  localparam logic [2:0] REG_ARM    = 3'd5;

  // Operations of the shared serial arithmetic unit.
  localparam logic [1:0] SU_MUL  = 2'd0;
  localparam logic [1:0] SU_DIV  = 2'd1;
  localparam logic [1:0] SU_SQRT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  joint;
    logic [15:0] target_pulse;
    logic [31:0] now_ms;
    logic        pwm_active;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_joint;
    logic [11:0] out_pulse;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/sjsp_serial_unit.sv =====
// Bit-serial multiply, divide and square root unit shared by all joints.
`default_nettype none
module sjsp_serial_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res
);
  // Multiply: res = a*b truncated to 64 bits. Divide: res = a / b. Root: res = isqrt(a).
  logic        busy;
  logic [1:0]  cur;
  logic [6:0]  cnt;
  logic [63:0] acc;
  logic [63:0] sh;
  logic [63:0] opb;
  logic [64:0] rem;
  logic [65:0] srem;
  logic [65:0] trial;
  logic [64:0] dtrial;

  always_comb begin
    dtrial = {rem[63:0], sh[63]} - {1'b0, opb};
    trial  = {srem[63:0], sh[63:62]} - {acc[63:0], 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cur  <= op;
      acc  <= '0;
      rem  <= '0;
      srem <= '0;
      sh   <= a;
      opb  <= b;
      cnt  <= (op == sjsp_pkg::SU_SQRT) ? 7'd32 : 7'd64;
    end else if (busy) begin
      unique case (cur)
        sjsp_pkg::SU_MUL: begin
          if (opb[0]) acc <= acc + sh;
          sh  <= sh << 1;
          opb <= opb >> 1;
        end
        sjsp_pkg::SU_DIV: begin
          if (!dtrial[64]) begin
            rem <= {1'b0, dtrial[63:0]};
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= {rem[63:0], sh[63]};
            acc <= {acc[62:0], 1'b0};
          end
          sh <= sh << 1;
        end
        default: begin
          if (!trial[65]) begin
            srem <= trial;
            acc  <= {acc[62:0], 1'b1};
          end else begin
            srem <= {srem[63:0], sh[63:62]};
            acc  <= {acc[62:0], 1'b0};
          end
          sh <= sh << 2;
        end
      endcase
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign res = acc;
endmodule
`default_nettype wire

// ===== hdl/staged_joint_slew_profiler_top.sv =====
// Top level of the staged joint slew profiler.
`default_nettype none
// The block holds up to JOINT_COUNT servo joints and steps them toward their
// goal pulse widths in two stages (joints 0 and 3, then joints 1 and 2).
// Set-target and home items give no result. An accepted tick (arm_enable,
// pwm_active and at least 20 ms since the last tick) emits one result item
// per joint in use, joint 0 first, with last set on the final one. The
// multiplies, divides and square roots run through one shared bit-serial
// unit that retires one bit (one root digit) per cycle: each joint in the
// running stage takes three multiplies, two divides and a square root,
// while a joint outside it has its speed cleared and only gives its result.
// With four joints in use two of them are in the running stage; a tick holds
// the block until its last result item is sent, and longer under any stall
// on the result side; that serial unit sets the rate. The block takes one
// item at a time. Configuration goes through the APB port, register i at 4*i.
module staged_joint_slew_profiler_top #(
  parameter int JOINT_COUNT = sjsp_pkg::JOINT_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sjsp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sjsp_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOOP, S_MUL_A, S_DIV_A, S_MUL_D, S_SQRT, S_MUL_S, S_DIV_S,
    S_APPLY, S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [2:0]  joints_in_use;
  logic [11:0] pulse_min, pulse_max;
  logic [15:0] accel_rate, max_rate;
  logic        arm_enable;

  logic [11:0] goal_pulse    [JOINT_COUNT];
  logic [11:0] present_pulse [JOINT_COUNT];
  logic [23:0] joint_speed   [JOINT_COUNT];
  logic        stage;
  logic [31:0] last_tick_ms;

  sjsp_pkg::in_item_t item;
  logic [JW:0]  idx;
  logic [15:0]  dt;
  logic [63:0]  sp;
  logic [11:0]  span;

  logic        su_start;
  logic [1:0]  su_op;
  logic [63:0] su_a, su_b, su_res;
  logic        su_done;

  sjsp_serial_unit u_su (
    .clk(clk), .rst(rst), .start(su_start), .op(su_op), .a(su_a), .b(su_b),
    .done(su_done), .res(su_res)
  );

  // Number of joints in use, clipped at the array depth and emit limit.
  logic [3:0] n_use;
  always_comb begin
    n_use = {1'b0, joints_in_use};
    if (n_use > 4'(JOINT_COUNT)) n_use = 4'(JOINT_COUNT);
    if (n_use > 4'(sjsp_pkg::MAX_EMIT)) n_use = 4'(sjsp_pkg::MAX_EMIT);
  end

  logic [7:0] mask0, mask_run;
  logic       arrived0;
  always_comb begin
    mask0 = sjsp_pkg::STAGE0_MASK;
    mask_run = stage ? sjsp_pkg::STAGE1_MASK : sjsp_pkg::STAGE0_MASK;
    arrived0 = 1'b1;
    for (int i = 0; i < JOINT_COUNT; i++) begin
      if (4'(i) < n_use && mask0[i] && present_pulse[i] != goal_pulse[i])
        arrived0 = 1'b0;
    end
  end

  logic [JW-1:0] ji;
  assign ji = idx[JW-1:0];

  // Joint addressed by a set-target item, sized to the joint arrays.
  logic [JW-1:0] jset;
  assign jset = JW'(item.joint);

  logic [11:0] clamp_c;
  logic [12:0] center;
  logic [31:0] dt_raw;
  always_comb begin
    if ({4'd0, pulse_min} > item.target_pulse) clamp_c = pulse_min;
    else if (item.target_pulse > {4'd0, pulse_max}) clamp_c = pulse_max;
    else clamp_c = item.target_pulse[11:0];
    center = ({1'b0, pulse_min} + {1'b0, pulse_max}) >> 1;
    dt_raw = item.now_ms - last_tick_ms;
  end

  logic [11:0] g_cur, p_cur;
  assign g_cur = goal_pulse[ji];
  assign p_cur = present_pulse[ji];

  assign in_ready = (state == S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      sjsp_pkg::REG_JOINTS: prdata = {29'd0, joints_in_use};
      sjsp_pkg::REG_PMIN:   prdata = {20'd0, pulse_min};
      sjsp_pkg::REG_PMAX:   prdata = {20'd0, pulse_max};
      sjsp_pkg::REG_ACCEL:  prdata = {16'd0, accel_rate};
      sjsp_pkg::REG_MAXR:   prdata = {16'd0, max_rate};
      sjsp_pkg::REG_ARM:    prdata = {31'd0, arm_enable};
      default:              prdata = '0;
    endcase
  end

  logic [63:0] cap;
  assign cap = {40'd0, max_rate, 8'd0};

  always_ff @(posedge clk) begin
    su_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      joints_in_use <= 3'd4; pulse_min <= 12'd500; pulse_max <= 12'd2500;
      accel_rate <= 16'd2000; max_rate <= 16'd1650; arm_enable <= 1'b0;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        goal_pulse[i] <= '0; present_pulse[i] <= '0; joint_speed[i] <= '0;
      end
      stage <= 1'b0;
      last_tick_ms <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          sjsp_pkg::REG_JOINTS: joints_in_use <= pwdata[2:0];
          sjsp_pkg::REG_PMIN:   pulse_min <= pwdata[11:0];
          sjsp_pkg::REG_PMAX:   pulse_max <= pwdata[11:0];
          sjsp_pkg::REG_ACCEL:  accel_rate <= pwdata[15:0];
          sjsp_pkg::REG_MAXR:   max_rate <= pwdata[15:0];
          sjsp_pkg::REG_ARM:    arm_enable <= pwdata[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_IDLE;
          idx <= '0;
          if (item.action == sjsp_pkg::ACT_SET) begin
            if ({2'd0, item.joint} < n_use) begin
              if (clamp_c != goal_pulse[jset]) stage <= 1'b0;
              goal_pulse[jset] <= clamp_c;
            end
          end else if (item.action == sjsp_pkg::ACT_HOME) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
              if (4'(i) < n_use) begin
                goal_pulse[i] <= center[11:0];
                present_pulse[i] <= center[11:0];
              end
            end
            last_tick_ms <= item.now_ms;
            stage <= 1'b0;
          end else if (item.action == sjsp_pkg::ACT_TICK) begin
            if (arm_enable && item.pwm_active && dt_raw >= sjsp_pkg::MIN_TICK_MS
                && n_use != 4'd0) begin
              last_tick_ms <= item.now_ms;
              dt <= (dt_raw > 32'd65535) ? 16'hFFFF : dt_raw[15:0];
              if (!stage && arrived0) stage <= 1'b1;
              state <= S_LOOP;
            end else if (arm_enable && item.pwm_active
                         && dt_raw >= sjsp_pkg::MIN_TICK_MS) begin
              last_tick_ms <= item.now_ms;
              if (!stage && arrived0) stage <= 1'b1;
            end
          end
        end
        S_LOOP: begin
          if (mask_run[ji]) begin
            span <= (g_cur > p_cur) ? g_cur - p_cur : p_cur - g_cur;
            su_op <= sjsp_pkg::SU_MUL;
            su_a <= {48'd0, accel_rate};
            su_b <= {40'd0, dt, 8'd0};
            su_start <= 1'b1;
            state <= S_MUL_A;
          end else begin
            joint_speed[ji] <= '0;
            state <= S_EMIT;
          end
        end
        S_MUL_A: if (su_done) begin
          su_op <= sjsp_pkg::SU_DIV; su_a <= su_res; su_b <= 64'd1000; su_start <= 1'b1;
          state <= S_DIV_A;
        end
        S_DIV_A: if (su_done) begin
          sp <= (su_res + {40'd0, joint_speed[ji]} > cap) ? cap
                : su_res + {40'd0, joint_speed[ji]};
          // Braking speed needs accel_rate times the distance left.
          su_op <= sjsp_pkg::SU_MUL;
          su_a <= {48'd0, accel_rate};
          su_b <= {52'd0, span};
          su_start <= 1'b1;
          state <= S_MUL_D;
        end
        S_MUL_D: if (su_done) begin
          su_op <= sjsp_pkg::SU_SQRT;
          su_a <= {su_res[46:0], 17'd0};
          su_start <= 1'b1;
          state <= S_SQRT;
        end
        S_SQRT: if (su_done) begin
          su_op <= sjsp_pkg::SU_MUL;
          su_a <= {40'd0, ((su_res < sp) ? su_res[23:0] : sp[23:0])};
          sp <= (su_res < sp) ? su_res : sp;
          su_b <= {48'd0, dt};
          su_start <= 1'b1;
          state <= S_MUL_S;
        end
        S_MUL_S: if (su_done) begin
          joint_speed[ji] <= sp[23:0];
          su_op <= sjsp_pkg::SU_DIV; su_a <= su_res; su_b <= 64'd256000; su_start <= 1'b1;
          state <= S_DIV_S;
        end
        S_DIV_S: if (su_done) begin
          sp <= (su_res == 64'd0) ? 64'd1 : su_res;
          state <= S_APPLY;
        end
        S_APPLY: begin
          if ({52'd0, span} > sp)
            present_pulse[ji] <= (g_cur > p_cur) ? p_cur + sp[11:0] : p_cur - sp[11:0];
          else
            present_pulse[ji] <= g_cur;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.out_joint <= 2'(idx);
            out_data.out_pulse <= present_pulse[ji];
            out_data.last <= (4'(idx) + 4'd1 == n_use);
            if (4'(idx) + 4'd1 == n_use) state <= S_IDLE;
            else begin
              idx <= idx + 1'b1;
              state <= S_LOOP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_EMIT)) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");
  a_done: assert property (@(posedge clk) disable iff (rst)
    su_done |-> (state != S_IDLE))
    else $error("serial unit finished with no joint in work");
`endif
endmodule
`default_nettype wire
